// ===== hw/rtl/barometer_compensation_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Barometer compensation unit assertion macros
// Shared concurrent assertion forms for the compensation pipeline.
// ----------------------------------------------------------------------------
`ifndef BAROMETER_COMPENSATION_UNIT_MACROS_SVH
`define BAROMETER_COMPENSATION_UNIT_MACROS_SVH

// implication checked outside reset
`define BCU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, also checked during reset
`define BCU_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bcu_pkg.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation package
// Field widths, register indexes and formula constants.
// ----------------------------------------------------------------------------
`default_nettype none

package bcu_pkg;

  localparam int RAW_W     = 24;
  localparam int CAL_W     = 16;
  localparam int OUT_W     = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] REG_PRESS_SENS    = 3'd0;
  localparam logic [2:0] REG_PRESS_OFFSET  = 3'd1;
  localparam logic [2:0] REG_SENS_TCOEFF   = 3'd2;
  localparam logic [2:0] REG_OFFSET_TCOEFF = 3'd3;
  localparam logic [2:0] REG_REF_TEMP      = 3'd4;
  localparam logic [2:0] REG_TEMP_SLOPE    = 3'd5;

  localparam logic signed [19:0] TEMP_BASE = 20'sd2000;
  localparam logic signed [19:0] TEMP_LOW  = -20'sd1500;

  localparam logic signed [47:0] OFF2_GAIN      = 48'sd61;
  localparam logic signed [47:0] OFF2_LOW_GAIN  = 48'sd15;
  localparam logic signed [47:0] SENS2_GAIN     = 48'sd2;
  localparam logic signed [47:0] SENS2_LOW_GAIN = 48'sd8;

endpackage

`default_nettype wire

// ===== hw/rtl/bcu_in_if.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation input channel
// Valid/ready channel carrying one raw temperature and pressure pair.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcu_in_if;
  logic                        valid;
  logic                        ready;
  logic [bcu_pkg::RAW_W-1:0]   raw_temp;
  logic [bcu_pkg::RAW_W-1:0]   raw_press;

  modport source (output valid, output raw_temp, output raw_press, input ready);
  modport sink   (input valid, input raw_temp, input raw_press, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bcu_out_if.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation output channel
// Valid/ready channel carrying compensated temperature and pressure.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcu_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bcu_pkg::OUT_W-1:0]  temp_centi_c;
  logic signed [bcu_pkg::OUT_W-1:0]  press_centi_mbar;

  modport source (output valid, output temp_centi_c, output press_centi_mbar,
                  input ready);
  modport sink   (input valid, input temp_centi_c, input press_centi_mbar,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/barometer_compensation_unit.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation unit
// Throughput: one item per cycle while result.ready is high; nine register
// stages with per-stage valid bits, a stalled stage only holds items behind
// it up to a bubble. Reset: synchronous, clears all stage valid bits and the
// six calibration registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none
`include "barometer_compensation_unit_macros.svh"

module barometer_compensation_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [bcu_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [bcu_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [bcu_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                   pready,
  bcu_in_if.sink                                 sample,
  bcu_out_if.source                              result
);

  localparam int NSTAGE = 9;

  // calibration registers
  logic [bcu_pkg::CAL_W-1:0] pressure_sensitivity;
  logic [bcu_pkg::CAL_W-1:0] pressure_offset;
  logic [bcu_pkg::CAL_W-1:0] sensitivity_temp_coeff;
  logic [bcu_pkg::CAL_W-1:0] offset_temp_coeff;
  logic [bcu_pkg::CAL_W-1:0] reference_temperature;
  logic [bcu_pkg::CAL_W-1:0] temperature_slope;

  logic [2:0] reg_idx;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_sensitivity   <= '0;
      pressure_offset        <= '0;
      sensitivity_temp_coeff <= '0;
      offset_temp_coeff      <= '0;
      reference_temperature  <= '0;
      temperature_slope      <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        bcu_pkg::REG_PRESS_SENS:    pressure_sensitivity   <= pwdata[15:0];
        bcu_pkg::REG_PRESS_OFFSET:  pressure_offset        <= pwdata[15:0];
        bcu_pkg::REG_SENS_TCOEFF:   sensitivity_temp_coeff <= pwdata[15:0];
        bcu_pkg::REG_OFFSET_TCOEFF: offset_temp_coeff      <= pwdata[15:0];
        bcu_pkg::REG_REF_TEMP:      reference_temperature  <= pwdata[15:0];
        bcu_pkg::REG_TEMP_SLOPE:    temperature_slope      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bcu_pkg::REG_PRESS_SENS:    prdata = {16'd0, pressure_sensitivity};
      bcu_pkg::REG_PRESS_OFFSET:  prdata = {16'd0, pressure_offset};
      bcu_pkg::REG_SENS_TCOEFF:   prdata = {16'd0, sensitivity_temp_coeff};
      bcu_pkg::REG_OFFSET_TCOEFF: prdata = {16'd0, offset_temp_coeff};
      bcu_pkg::REG_REF_TEMP:      prdata = {16'd0, reference_temperature};
      bcu_pkg::REG_TEMP_SLOPE:    prdata = {16'd0, temperature_slope};
      default:                    prdata = '0;
    endcase
  end

  // pipeline control
  logic [NSTAGE-1:0] v;
  logic [NSTAGE-1:0] en;

  always_comb begin
    en[NSTAGE-1] = !v[NSTAGE-1] || result.ready;
    for (int k = NSTAGE-2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign sample.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= sample.valid;
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 0: temperature difference
  logic [23:0]        s0_d1;
  logic signed [24:0] s0_dt;
  logic signed [24:0] s0_dt_next;

  assign s0_dt_next = $signed({1'b0, sample.raw_temp})
                    - $signed({1'b0, reference_temperature, 8'h00});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_d1 <= sample.raw_press;
      s0_dt <= s0_dt_next;
    end
  end

  // stage 1: first-order products
  logic signed [16:0] c3s, c4s, c6s;
  logic [23:0]        s1_d1;
  logic signed [41:0] s1_pt, s1_poff, s1_psens;
  logic signed [49:0] s1_pdd;
  logic signed [41:0] s1_pt_next, s1_poff_next, s1_psens_next;
  logic signed [49:0] s1_pdd_next;

  assign c3s = $signed({1'b0, sensitivity_temp_coeff});
  assign c4s = $signed({1'b0, offset_temp_coeff});
  assign c6s = $signed({1'b0, temperature_slope});

  assign s1_pt_next    = s0_dt * c6s;
  assign s1_poff_next  = s0_dt * c4s;
  assign s1_psens_next = s0_dt * c3s;
  assign s1_pdd_next   = s0_dt * s0_dt;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_d1    <= s0_d1;
      s1_pt    <= s1_pt_next;
      s1_poff  <= s1_poff_next;
      s1_psens <= s1_psens_next;
      s1_pdd   <= s1_pdd_next;
    end
  end

  // stage 2: first-order temperature, offset, sensitivity
  logic [23:0]        s2_d1;
  logic signed [18:0] s2_x, s2_x_next;
  logic signed [19:0] s2_temp1, s2_temp1_next;
  logic signed [19:0] s2_vl, s2_vl_next;
  logic signed [37:0] s2_off1, s2_off1_next;
  logic signed [37:0] s2_sens1, s2_sens1_next;
  logic signed [18:0] s2_t2, s2_t2_next;
  logic               s2_low, s2_vlow;

  assign s2_x_next     = $signed(s1_pt[41:23]);
  assign s2_temp1_next = 20'(s2_x_next) + bcu_pkg::TEMP_BASE;
  assign s2_vl_next    = s2_temp1_next - bcu_pkg::TEMP_LOW;
  assign s2_off1_next  = 38'($signed({1'b0, pressure_offset, 17'd0}))
                       + 38'($signed(s1_poff[41:6]));
  assign s2_sens1_next = 38'($signed({1'b0, pressure_sensitivity, 16'd0}))
                       + 38'($signed(s1_psens[41:7]));
  assign s2_t2_next    = $signed(s1_pdd[49:31]);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_d1    <= s1_d1;
      s2_x     <= s2_x_next;
      s2_temp1 <= s2_temp1_next;
      s2_vl    <= s2_vl_next;
      s2_off1  <= s2_off1_next;
      s2_sens1 <= s2_sens1_next;
      s2_t2    <= s2_t2_next;
      s2_low   <= s2_temp1_next < bcu_pkg::TEMP_BASE;
      s2_vlow  <= s2_temp1_next < bcu_pkg::TEMP_LOW;
    end
  end

  // stage 3: squares for second-order terms
  logic [23:0]        s3_d1;
  logic signed [37:0] s3_td2;
  logic signed [39:0] s3_vl2;
  logic signed [19:0] s3_temp1;
  logic signed [37:0] s3_off1, s3_sens1;
  logic signed [18:0] s3_t2;
  logic               s3_low, s3_vlow;
  logic signed [37:0] s3_td2_next;
  logic signed [39:0] s3_vl2_next;

  assign s3_td2_next = s2_x * s2_x;
  assign s3_vl2_next = s2_vl * s2_vl;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_d1    <= s2_d1;
      s3_td2   <= s3_td2_next;
      s3_vl2   <= s3_vl2_next;
      s3_temp1 <= s2_temp1;
      s3_off1  <= s2_off1;
      s3_sens1 <= s2_sens1;
      s3_t2    <= s2_t2;
      s3_low   <= s2_low;
      s3_vlow  <= s2_vlow;
    end
  end

  // stage 4: second-order offset and sensitivity
  logic [23:0]        s4_d1;
  logic signed [47:0] s4_off2, s4_sens2;
  logic signed [19:0] s4_temp1;
  logic signed [37:0] s4_off1, s4_sens1;
  logic signed [18:0] s4_t2;
  logic               s4_low;
  logic signed [47:0] off2_prod;
  logic signed [47:0] s4_off2_next, s4_sens2_next;

  assign off2_prod     = 48'(s3_td2) * bcu_pkg::OFF2_GAIN;
  assign s4_off2_next  = (off2_prod >>> 4)
                       + (s3_vlow ? 48'(s3_vl2) * bcu_pkg::OFF2_LOW_GAIN : 48'sd0);
  assign s4_sens2_next = 48'(s3_td2) * bcu_pkg::SENS2_GAIN
                       + (s3_vlow ? 48'(s3_vl2) * bcu_pkg::SENS2_LOW_GAIN : 48'sd0);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_d1    <= s3_d1;
      s4_off2  <= s4_off2_next;
      s4_sens2 <= s4_sens2_next;
      s4_temp1 <= s3_temp1;
      s4_off1  <= s3_off1;
      s4_sens1 <= s3_sens1;
      s4_t2    <= s3_t2;
      s4_low   <= s3_low;
    end
  end

  // stage 5: apply second-order correction
  logic [23:0]        s5_d1;
  logic signed [20:0] s5_temp;
  logic signed [47:0] s5_off, s5_sens;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_d1   <= s4_d1;
      s5_temp <= s4_low ? 21'(s4_temp1) - 21'(s4_t2) : 21'(s4_temp1);
      s5_off  <= s4_low ? 48'(s4_off1) - s4_off2 : 48'(s4_off1);
      s5_sens <= s4_low ? 48'(s4_sens1) - s4_sens2 : 48'(s4_sens1);
    end
  end

  // stage 6: pressure partial products
  logic [47:0]        s6_pp_lo, s6_pp_lo_next;
  logic signed [48:0] s6_pp_hi, s6_pp_hi_next;
  logic signed [47:0] s6_off;
  logic signed [20:0] s6_temp;

  assign s6_pp_lo_next = s5_d1 * s5_sens[23:0];
  assign s6_pp_hi_next = $signed({1'b0, s5_d1}) * $signed(s5_sens[47:24]);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_pp_lo <= s6_pp_lo_next;
      s6_pp_hi <= s6_pp_hi_next;
      s6_off   <= s5_off;
      s6_temp  <= s5_temp;
    end
  end

  // stage 7: combine partial products
  logic signed [71:0] s7_prod;
  logic signed [47:0] s7_off;
  logic signed [20:0] s7_temp;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_prod <= (72'(s6_pp_hi) <<< 24) + 72'($signed({1'b0, s6_pp_lo}));
      s7_off  <= s6_off;
      s7_temp <= s6_temp;
    end
  end

  // stage 8: final pressure and output register
  logic signed [51:0] press_diff;
  logic signed [31:0] s8_temp, s8_press;

  assign press_diff = 52'($signed(s7_prod[71:21])) - 52'(s7_off);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_temp  <= 32'(s7_temp);
      s8_press <= 32'(press_diff >>> 15);
    end
  end

  assign result.valid            = v[NSTAGE-1];
  assign result.temp_centi_c     = s8_temp;
  assign result.press_centi_mbar = s8_press;

  `BCU_ASSERT_IMP(a_drain_ready, clk, rst, result.ready, sample.ready,
                  "pipeline refuses an item while the output is taken")
  `BCU_ASSERT_IMP(a_low_flags, clk, rst, v[2] && s2_vlow, s2_low,
                  "very low temperature flag set without low temperature flag")
  `BCU_ASSERT_NEXT(a_reset_empty, clk, rst, !result.valid,
                   "result valid right after reset")

endmodule

`default_nettype wire

// ===== tb/barometer_compensation_unit_checker.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation checker
// Watches the configuration port and both item channels. Keeps its own copy of
// the six calibration words, computes the compensated temperature and pressure
// for every accepted item and compares each delivered result, field by field,
// with the oldest outstanding reading.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module barometer_compensation_unit_checker
  import bcu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  bcu_in_if                     sample,
  bcu_out_if                    result,
  output int                    failures,
  output int                    pending,
  output int                    checked
);

  typedef struct {
    logic signed [OUT_W-1:0] temp;
    logic signed [OUT_W-1:0] press;
  } reading_t;

  localparam longint BASE_TEMP  = TEMP_BASE;
  localparam longint COLD_TEMP  = TEMP_LOW;
  localparam longint OFF2_K     = OFF2_GAIN;
  localparam longint OFF2_COLD  = OFF2_LOW_GAIN;
  localparam longint SENS2_K    = SENS2_GAIN;
  localparam longint SENS2_COLD = SENS2_LOW_GAIN;

  logic [CAL_W-1:0] cal_word [6];
  reading_t         expected_readings [$];
  int               fail_count = 0;
  int               check_count = 0;
  int               pending_q = 0;
  int               failures_q = 0;
  int               checked_q = 0;

  assign failures = failures_q;
  assign pending  = pending_q;
  assign checked  = checked_q;

  function automatic reading_t compensate(input logic [RAW_W-1:0] raw_t,
                                          input logic [RAW_W-1:0] raw_p);
    longint   dt;
    longint   temp;
    longint   off;
    longint   sens;
    longint   td;
    longint   cold;
    longint   press;
    reading_t r;
    dt   = longint'(raw_t) - longint'(cal_word[REG_REF_TEMP]) * 256;
    temp = BASE_TEMP + ((dt * longint'(cal_word[REG_TEMP_SLOPE])) >>> 23);
    off  = longint'(cal_word[REG_PRESS_OFFSET]) * 131072
         + ((longint'(cal_word[REG_OFFSET_TCOEFF]) * dt) >>> 6);
    sens = longint'(cal_word[REG_PRESS_SENS]) * 65536
         + ((longint'(cal_word[REG_SENS_TCOEFF]) * dt) >>> 7);
    if (temp < BASE_TEMP) begin
      td   = temp - BASE_TEMP;
      off  = off - ((OFF2_K * td * td) >>> 4);
      sens = sens - SENS2_K * td * td;
      if (temp < COLD_TEMP) begin
        cold = temp - COLD_TEMP;
        off  = off - OFF2_COLD * cold * cold;
        sens = sens - SENS2_COLD * cold * cold;
      end
      temp = temp - ((dt * dt) >>> 31);
    end
    press   = ((((longint'(raw_p) * sens) >>> 21) - off) >>> 15);
    r.temp  = temp[OUT_W-1:0];
    r.press = press[OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      foreach (cal_word[i]) cal_word[i] = '0;
      expected_readings.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[CFG_ADDR_W-1:2] <= REG_TEMP_SLOPE)
        cal_word[paddr[CFG_ADDR_W-1:2]] = pwdata[CAL_W-1:0];
      if (sample.valid && sample.ready)
        expected_readings.push_back(compensate(sample.raw_temp, sample.raw_press));
      if (result.valid && result.ready) begin
        if (expected_readings.size() == 0) begin
          $error("unexpected result: temp_centi_c %0d press_centi_mbar %0d",
                 result.temp_centi_c, result.press_centi_mbar);
          fail_count++;
        end else begin
          want = expected_readings.pop_front();
          check_count++;
          if (result.temp_centi_c !== want.temp) begin
            $error("temp_centi_c: expected %0d, actual %0d", want.temp,
                   result.temp_centi_c);
            fail_count++;
          end
          if (result.press_centi_mbar !== want.press) begin
            $error("press_centi_mbar: expected %0d, actual %0d", want.press,
                   result.press_centi_mbar);
            fail_count++;
          end
        end
      end
    end
    pending_q  <= expected_readings.size();
    failures_q <= fail_count;
    checked_q  <= check_count;
  end

endmodule

// ===== tb/barometer_compensation_unit_test.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation unit test
// Loads calibration sets over the configuration port while the pipeline is
// empty, sends directed corner items (zero and full-scale conversions, the
// 20.00 and -15.00 degC thresholds, truncated register writes, spare register
// writes) and then random items under three idle mixes on both channels. The
// checker predicts every reading and compares the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module barometer_compensation_unit_test;
  import bcu_pkg::*;

  typedef logic [CAL_W-1:0] cal_set_t [6];

  localparam int               WATCHDOG_LIMIT = 4000;
  localparam int               DRAIN_CYCLES   = 16;
  localparam int               PHASE_ITEMS    = 100;
  localparam logic [2:0]       REG_SPARE_LO   = REG_TEMP_SLOPE + 3'd1;
  localparam logic [2:0]       REG_SPARE_HI   = REG_TEMP_SLOPE + 3'd2;
  localparam logic [RAW_W-1:0] RAW_MAX        = {RAW_W{1'b1}};
  localparam longint           RAW_TOP        = 16777215;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  result_take = 1'b0;
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  int                    send_idle_mix [3] = '{26, 71, 0};
  int                    recv_idle_mix [3] = '{71, 26, 0};
  int                    failures;
  int                    pending;
  int                    checked;
  int                    items_sent = 0;
  int                    settings_used = 1;
  int                    stall_cycles = 0;

  bcu_in_if  sample_ch();
  bcu_out_if result_ch();

  assign result_ch.ready = result_take;

  barometer_compensation_unit uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sample  (sample_ch),
    .result  (result_ch)
  );

  barometer_compensation_unit_checker compensation_check (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .sample   (sample_ch),
    .result   (result_ch),
    .failures (failures),
    .pending  (pending),
    .checked  (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      result_take <= 1'b0;
    end else begin
      result_take <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("barometer_compensation_unit_test: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(input logic [RAW_W-1:0] raw_t, input logic [RAW_W-1:0] raw_p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.raw_temp  <= raw_t;
    sample_ch.raw_press <= raw_p;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [CAL_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic load_calibration(input cal_set_t words);
    wait_drained();
    write_reg(REG_PRESS_SENS, words[REG_PRESS_SENS]);
    write_reg(REG_PRESS_OFFSET, words[REG_PRESS_OFFSET]);
    write_reg(REG_SENS_TCOEFF, words[REG_SENS_TCOEFF]);
    write_reg(REG_OFFSET_TCOEFF, words[REG_OFFSET_TCOEFF]);
    write_reg(REG_REF_TEMP, words[REG_REF_TEMP]);
    write_reg(REG_TEMP_SLOPE, words[REG_TEMP_SLOPE]);
    write_reg(REG_SPARE_LO, 16'($urandom));
    write_reg(REG_SPARE_HI, 16'($urandom));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic random_phase(input int count);
    cal_set_t         words;
    longint           centre;
    longint           raw_t;
    logic [RAW_W-1:0] raw_p;
    foreach (words[i]) begin
      case ($urandom_range(0, 9))
        0:       words[i] = '0;
        1:       words[i] = '1;
        default: words[i] = 16'($urandom);
      endcase
    end
    load_calibration(words);
    centre = longint'(words[REG_REF_TEMP]) * 256;
    repeat (count) begin
      case ($urandom_range(0, 3))
        0: raw_t = longint'($urandom_range(0, RAW_TOP));
        1: raw_t = centre + longint'($urandom_range(0, 2097152)) - 1048576;
        2: raw_t = centre + longint'($urandom_range(0, 8192)) - 4096;
        default: begin
          if ($urandom_range(0, 1) == 0) raw_t = longint'($urandom_range(0, 255));
          else raw_t = RAW_TOP - longint'($urandom_range(0, 255));
        end
      endcase
      if (raw_t < 0) raw_t = 0;
      else if (raw_t > RAW_TOP) raw_t = RAW_TOP;
      case ($urandom_range(0, 7))
        0:       raw_p = '0;
        1:       raw_p = RAW_MAX;
        default: raw_p = RAW_W'($urandom);
      endcase
      send_item(RAW_W'(raw_t), raw_p);
    end
  endtask

  initial begin
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    sample_ch.valid     = 1'b0;
    sample_ch.raw_temp  = '0;
    sample_ch.raw_press = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item('0, '0);
    send_item(RAW_MAX, RAW_MAX);
    send_item('0, RAW_MAX);
    send_item(RAW_MAX, '0);

    // hit 20.00 and -15.00 degC exactly and one step below each
    load_calibration('{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd40000, 16'd32768});
    send_item(24'd10240000, 24'd6465444);
    send_item(24'd10239999, 24'd6465444);
    send_item(24'd9344000, 24'd6465444);
    send_item(24'd9343999, 24'd6465444);
    send_item('0, RAW_MAX);
    send_item(RAW_MAX, RAW_MAX);

    load_calibration('{default: '1});
    send_item('0, '0);
    send_item(RAW_MAX, RAW_MAX);
    send_item('0, RAW_MAX);
    send_item(RAW_MAX, '0);
    send_item(24'h800000, 24'h800000);

    load_calibration('{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165});
    send_item(24'd8077636, 24'd6465444);
    send_item(24'd8077568, 24'd6465444);
    send_item(24'd2000000, 24'd9000000);

    for (int mix = 0; mix < 3; mix++) begin
      send_idle_pct = send_idle_mix[mix];
      recv_idle_pct = recv_idle_mix[mix];
      repeat (3) random_phase(PHASE_ITEMS);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d items sent under %0d calibration settings and three idle mixes,",
             items_sent, settings_used);
    $display("%0d results compared, %0d mismatches", checked, failures);
    if (failures == 0) begin
      $display("barometer_compensation_unit_test: PASS");
    end else begin
      $display("barometer_compensation_unit_test: FAIL");
    end
    $finish;
  end

endmodule
